@@ src/e2q_pkg.sv @@
package e2q_pkg;

   localparam int ATAN_ENTRIES = 24;
   localparam int WORD_W = 32;
   localparam int FIELD_W = 16;
   localparam logic signed [WORD_W-1:0] GAIN_Q30 = 32'sd652032874;
   localparam logic signed [WORD_W-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
      32'sd15000234, 32'sd7507429, 32'sd3754631, 32'sd1877430,
      32'sd938729, 32'sd469366, 32'sd234683, 32'sd117342,
      32'sd58671, 32'sd29335, 32'sd14668, 32'sd7334,
      32'sd3667, 32'sd1833, 32'sd917, 32'sd458,
      32'sd229, 32'sd115, 32'sd57, 32'sd29
   };

   // half angle in 2^-22 degree, folded into [-90, 90]
   typedef struct packed {
      logic signed [WORD_W-1:0] z;
      logic                     neg;
   } e2q_lane_type;

   // lane 0 x, lane 1 y, lane 2 z
   typedef e2q_lane_type [2:0] e2q_job_type;

   function automatic logic signed [WORD_W-1:0] mulq(input logic signed [WORD_W-1:0] a,
                                                     input logic signed [WORD_W-1:0] b);
      logic signed [2*WORD_W-1:0] p;
      p = a * b;
      p = p + 64'sd536870912;
      return WORD_W'(p >>> 30);
   endfunction

endpackage

@@ src/e2q_front.sv @@
module e2q_front #(
   parameter int ANGLE_FRAC_BITS = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,
   output logic                 job_valid,
   input  logic                 job_ready,
   output e2q_pkg::e2q_job_type job_data
);

   localparam logic signed [31:0] MOD = 32'sd720 <<< ANGLE_FRAC_BITS;
   localparam logic signed [31:0] HALF = 32'sd360 <<< ANGLE_FRAC_BITS;
   localparam logic signed [31:0] QTR = 32'sd180 <<< ANGLE_FRAC_BITS;
   localparam int SHZ = 21 - ANGLE_FRAC_BITS;
   localparam logic [23:0] RECIP = 24'((64'd1 << 32) / 64'(MOD));

   logic                 en;
   logic                 v1_ff, v1_in, v2_ff, v2_in;
   logic [15:0]          mag_ff [3], mag_in [3];
   logic [15:0]          q_ff [3], q_in [3];
   logic [2:0]           sign_ff, sign_in;
   e2q_pkg::e2q_job_type job_ff, job_in;

   assign en = !v2_ff || job_ready;
   assign req_tready = en;
   assign v1_in = req_tvalid;
   assign v2_in = v1_ff;
   assign job_valid = v2_ff;
   assign job_data = job_ff;

   for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [15:0]        a;
      logic [39:0]        prod;
      logic signed [31:0] qm, rem0, rem, sr, wr;

      // estimate of the wrap count, at most one short
      assign a = req_tdata[16*l +: 16];
      assign sign_in[l] = a[15];
      assign mag_in[l] = a[15] ? 16'(~a + 16'd1) : a;
      assign prod = 40'(mag_in[l]) * 40'(RECIP);
      assign q_in[l] = 16'(prod >> 32);

      assign qm = $signed({16'd0, q_ff[l]}) * MOD;
      assign rem0 = $signed({16'd0, mag_ff[l]}) - qm;
      assign rem = (rem0 >= MOD) ? rem0 - MOD : rem0;
      assign sr = sign_ff[l] ? -rem : rem;
      assign wr = (sr > HALF) ? sr - MOD : ((sr <= -HALF) ? sr + MOD : sr);

      always_comb begin
         if (wr > QTR) begin
            job_in[l].z = (wr - 2 * QTR) <<< SHZ;
            job_in[l].neg = 1'b1;
         end else if (wr < -QTR) begin
            job_in[l].z = (wr + 2 * QTR) <<< SHZ;
            job_in[l].neg = 1'b1;
         end else begin
            job_in[l].z = wr <<< SHZ;
            job_in[l].neg = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
         q_ff <= q_in;
         sign_ff <= sign_in;
         job_ff <= job_in;
      end
   end

endmodule

@@ src/e2q_queue.sv @@
module e2q_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  e2q_pkg::e2q_job_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output e2q_pkg::e2q_job_type out_data
);

   e2q_pkg::e2q_job_type mem_ff [2];
   logic                 wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign wp_in = push ? !wp_ff : wp_ff;
   assign rp_in = pop ? !rp_ff : rp_ff;

   always_comb begin
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end

endmodule

@@ src/e2q_back.sv @@
module e2q_back #(
   parameter int CORDIC_STAGES = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  e2q_pkg::e2q_job_type job_data,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_tdata
);

   localparam int NS = (CORDIC_STAGES < e2q_pkg::ATAN_ENTRIES) ?
                       CORDIC_STAGES : e2q_pkg::ATAN_ENTRIES;
   localparam int SHO = 30 - OUT_FRAC_BITS;
   localparam logic signed [33:0] RND = 34'sd1 <<< ((SHO > 0) ? SHO - 1 : 0);
   localparam logic signed [33:0] RNDV = (SHO > 0) ? RND : 34'sd0;
   localparam logic signed [33:0] ONE = 34'sd1 <<< OUT_FRAC_BITS;

   logic                     en;
   logic signed [31:0]       cx_ff [NS+1][3], cx_in [NS+1][3];
   logic signed [31:0]       cy_ff [NS+1][3], cy_in [NS+1][3];
   logic signed [31:0]       cz_ff [NS+1][3], cz_in [NS+1][3];
   logic [2:0]               cneg_ff [NS+1], cneg_in [NS+1];
   logic [NS:0]              cv_ff, cv_in;
   logic [3:0]               sv_ff, sv_in;
   logic signed [31:0]       s_ff [3], s_in [3], c_ff [3], c_in [3];
   logic signed [31:0]       t_ff [4], t_in [4];
   logic signed [31:0]       tsx_ff, tcx_ff;
   logic signed [31:0]       p_ff [8], p_in [8];
   logic [63:0]              out_ff, out_in;
   logic signed [32:0]       v0, v1, v2, v3;

   function automatic logic [15:0] to_out(input logic signed [32:0] v);
      logic signed [33:0] r;
      r = (34'(v) + RNDV) >>> SHO;
      if (r > ONE) begin
         r = ONE;
      end
      if (r < -ONE) begin
         r = -ONE;
      end
      return 16'(r);
   endfunction

   assign en = !sv_ff[3] || rsp_tready;
   assign job_ready = en;
   assign cv_in = {cv_ff[NS-1:0], job_valid};
   assign sv_in = {sv_ff[2:0], cv_ff[NS]};
   assign rsp_tvalid = sv_ff[3];
   assign rsp_tdata = out_ff;

   for (genvar l = 0; l < 3; l++) begin : g_lane
      assign cx_in[0][l] = e2q_pkg::GAIN_Q30;
      assign cy_in[0][l] = 32'sd0;
      assign cz_in[0][l] = job_data[l].z;
      assign cneg_in[0][l] = job_data[l].neg;
      for (genvar i = 0; i < NS; i++) begin : g_iter
         logic signed [31:0] dx, dy;
         assign dx = cy_ff[i][l] >>> i;
         assign dy = cx_ff[i][l] >>> i;
         assign cx_in[i+1][l] = cz_ff[i][l][31] ? cx_ff[i][l] + dx : cx_ff[i][l] - dx;
         assign cy_in[i+1][l] = cz_ff[i][l][31] ? cy_ff[i][l] - dy : cy_ff[i][l] + dy;
         assign cz_in[i+1][l] = cz_ff[i][l][31] ? cz_ff[i][l] + e2q_pkg::ATAN_TABLE[i] :
                                                  cz_ff[i][l] - e2q_pkg::ATAN_TABLE[i];
         assign cneg_in[i+1][l] = cneg_ff[i][l];
      end
      assign s_in[l] = cneg_ff[NS][l] ? -cy_ff[NS][l] : cy_ff[NS][l];
      assign c_in[l] = cneg_ff[NS][l] ? -cx_ff[NS][l] : cx_ff[NS][l];
   end

   // qz * qy
   assign t_in[0] = -e2q_pkg::mulq(s_ff[2], s_ff[1]);
   assign t_in[1] = e2q_pkg::mulq(c_ff[2], s_ff[1]);
   assign t_in[2] = e2q_pkg::mulq(s_ff[2], c_ff[1]);
   assign t_in[3] = e2q_pkg::mulq(c_ff[2], c_ff[1]);

   // (qz * qy) * qx
   assign p_in[0] = e2q_pkg::mulq(t_ff[0], tcx_ff);
   assign p_in[1] = e2q_pkg::mulq(t_ff[3], tsx_ff);
   assign p_in[2] = e2q_pkg::mulq(t_ff[1], tcx_ff);
   assign p_in[3] = e2q_pkg::mulq(t_ff[2], tsx_ff);
   assign p_in[4] = e2q_pkg::mulq(t_ff[1], tsx_ff);
   assign p_in[5] = e2q_pkg::mulq(t_ff[2], tcx_ff);
   assign p_in[6] = e2q_pkg::mulq(t_ff[0], tsx_ff);
   assign p_in[7] = e2q_pkg::mulq(t_ff[3], tcx_ff);

   assign v0 = 33'(p_ff[0]) + 33'(p_ff[1]);
   assign v1 = 33'(p_ff[2]) + 33'(p_ff[3]);
   assign v2 = 33'(p_ff[5]) - 33'(p_ff[4]);
   assign v3 = 33'(p_ff[7]) - 33'(p_ff[6]);
   assign out_in = {to_out(v3), to_out(v2), to_out(v1), to_out(v0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= '0;
         sv_ff <= '0;
      end else if (en) begin
         cv_ff <= cv_in;
         sv_ff <= sv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
         cneg_ff <= cneg_in;
         s_ff <= s_in;
         c_ff <= c_in;
         t_ff <= t_in;
         tsx_ff <= s_ff[0];
         tcx_ff <= c_ff[0];
         p_ff <= p_in;
         out_ff <= out_in;
      end
   end

endmodule

@@ src/euler_to_quaternion.sv @@
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata: angle_x, angle_y, angle_z
// rsp      out  rsp_tvalid/rsp_tready  tdata: quat_x, quat_y, quat_z, quat_w
//
// one item per cycle while the rsp side does not stall; with the queue empty an
// item passes through two angle-reduction stages, the queue slot, the cordic input
// register, the cordic stages (CORDIC_STAGES, at most ATAN_ENTRIES), a sign stage,
// two multiply stages and the output register
// synchronous reset clears valid bits and the two-entry queue
// a stalled rsp side freezes the back pipeline; the queue lets the front keep
// accepting until it fills
module euler_to_quaternion #(
   parameter int CORDIC_STAGES = 16,
   parameter int OUT_FRAC_BITS = 14,
   parameter int ANGLE_FRAC_BITS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // angle_x, angle_y, angle_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // quat_x, quat_y, quat_z, quat_w
);

   logic                 f_valid, f_ready, b_valid, b_ready;
   e2q_pkg::e2q_job_type f_data, b_data;

   e2q_front #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .job_valid(f_valid),
      .job_ready(f_ready),
      .job_data(f_data)
   );

   e2q_queue u_queue (
      .clock(clock),
      .reset(reset),
      .in_valid(f_valid),
      .in_ready(f_ready),
      .in_data(f_data),
      .out_valid(b_valid),
      .out_ready(b_ready),
      .out_data(b_data)
   );

   e2q_back #(
      .CORDIC_STAGES(CORDIC_STAGES),
      .OUT_FRAC_BITS(OUT_FRAC_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .job_valid(b_valid),
      .job_ready(b_ready),
      .job_data(b_data),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

endmodule

@@ bench/tb_euler_to_quaternion.sv @@
module tb_euler_to_quaternion;

   localparam int STAGES = 16;
   localparam int OUT_FRAC = 14;
   localparam int ANG_FRAC = 6;
   localparam int LATENCY = STAGES + 8;
   localparam int ANG_LIMIT = 23040;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;

   euler_to_quaternion #(
      .CORDIC_STAGES(STAGES), .OUT_FRAC_BITS(OUT_FRAC), .ANGLE_FRAC_BITS(ANG_FRAC)
   ) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   typedef logic signed [63:0] s64_t;

   logic [47:0] angle_queue[$];
   logic [63:0] quat_queue[$];
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          errors = 0;
   bit          hold_sender = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic s64_t shr_floor(input s64_t v, input int s);
      return v >>> s;
   endfunction

   function automatic void half_sin_cos(input logic signed [15:0] ang,
                                        output s64_t s, output s64_t c);
      s64_t full, quarter, z, x, y, dx, dy;
      bit   flip;
      full = s64_t'(360) <<< 22;
      quarter = s64_t'(90) <<< 22;
      z = s64_t'(ang) * (s64_t'(1) <<< (21 - ANG_FRAC));
      x = 652032874;
      y = 0;
      flip = 0;
      z = z % full;
      if (z > full / 2) z = z - full;
      else if (z <= -full / 2) z = z + full;
      if (z > quarter) begin
         z = z - 2 * quarter;
         flip = 1;
      end else if (z < -quarter) begin
         z = z + 2 * quarter;
         flip = 1;
      end
      for (int i = 0; i < STAGES && i < e2q_pkg::ATAN_ENTRIES; i++) begin
         dx = shr_floor(y, i);
         dy = shr_floor(x, i);
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - s64_t'(e2q_pkg::ATAN_TABLE[i]);
         end else begin
            x = x + dx; y = y - dy; z = z + s64_t'(e2q_pkg::ATAN_TABLE[i]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic s64_t q30_mul(input s64_t a, input s64_t b);
      return shr_floor(a * b + (s64_t'(1) <<< 29), 30);
   endfunction

   // components ordered x, y, z, w
   function automatic void hamilton(input s64_t a[4], input s64_t b[4], output s64_t r[4]);
      r[0] = q30_mul(a[0], b[3]) + q30_mul(a[1], b[2]) - q30_mul(a[2], b[1])
           + q30_mul(a[3], b[0]);
      r[1] = -q30_mul(a[0], b[2]) + q30_mul(a[1], b[3]) + q30_mul(a[2], b[0])
           + q30_mul(a[3], b[1]);
      r[2] = q30_mul(a[0], b[1]) - q30_mul(a[1], b[0]) + q30_mul(a[2], b[3])
           + q30_mul(a[3], b[2]);
      r[3] = -q30_mul(a[0], b[0]) - q30_mul(a[1], b[1]) - q30_mul(a[2], b[2])
           + q30_mul(a[3], b[3]);
   endfunction

   function automatic logic [15:0] to_q14(input s64_t v);
      s64_t r, one;
      int   sh;
      sh = 30 - OUT_FRAC;
      one = s64_t'(1) <<< OUT_FRAC;
      r = v;
      if (sh > 0) r = shr_floor(v + (s64_t'(1) <<< (sh - 1)), sh);
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[15:0];
   endfunction

   function automatic logic [63:0] euler_quat(input logic [47:0] angles);
      s64_t qx[4], qy[4], qz[4], t[4], q[4];
      s64_t s, c;
      half_sin_cos(angles[15:0], s, c);
      qx = '{s, 0, 0, c};
      half_sin_cos(angles[31:16], s, c);
      qy = '{0, s, 0, c};
      half_sin_cos(angles[47:32], s, c);
      qz = '{0, 0, s, c};
      hamilton(qz, qy, t);
      hamilton(t, qx, q);
      return {to_q14(q[3]), to_q14(q[2]), to_q14(q[1]), to_q14(q[0])};
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d", what,
               $signed(got), $signed(want));
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            quat_queue.push_back(euler_quat(req_tdata));
         end
         if (!(req_tvalid && !req_tready)) begin
            if (angle_queue.size() > 0 && !hold_sender &&
                $urandom_range(99, 0) >= send_idle_pct) begin
               req_tvalid <= 1;
               req_tdata <= angle_queue.pop_front();
            end else begin
               req_tvalid <= 0;
            end
         end
         rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      logic [63:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (quat_queue.size() == 0) begin
            $display("unexpected item %h", rsp_tdata);
            errors++;
         end else begin
            want = quat_queue.pop_front();
            if (rsp_tdata[15:0] != want[15:0])
               report_mismatch("quat_x", rsp_tdata[15:0], want[15:0]);
            if (rsp_tdata[31:16] != want[31:16])
               report_mismatch("quat_y", rsp_tdata[31:16], want[31:16]);
            if (rsp_tdata[47:32] != want[47:32])
               report_mismatch("quat_z", rsp_tdata[47:32], want[47:32]);
            if (rsp_tdata[63:48] != want[63:48])
               report_mismatch("quat_w", rsp_tdata[63:48], want[63:48]);
         end
      end
   end

   function automatic logic [15:0] rand_angle();
      int r;
      r = $urandom_range(9, 0);
      if (r == 0) return 16'($urandom);
      if (r == 1) return 16'($signed($urandom_range(2 * ANG_LIMIT, 0)) - ANG_LIMIT);
      if (r == 2) return 16'($signed($urandom_range(256, 0)) - 128);
      if (r == 3) return 16'(($signed($urandom_range(16, 0)) - 8) * 90 * 64
                             + $signed($urandom_range(2, 0)) - 1);
      return 16'($signed($urandom_range(2 * ANG_LIMIT, 0)) - ANG_LIMIT);
   endfunction

   task automatic wait_drained();
      while (angle_queue.size() > 0 || req_tvalid || quat_queue.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic [15:0] edge_angles[] = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd5760,
         -16'sd5760, 16'sd11520, -16'sd11520, 16'sd17280, 16'sh7fff, 16'sh8000,
         16'sd1, -16'sd1, 16'sd5761, 16'sd11521};
      repeat (7) @(posedge clock);
      reset <= 0;
      foreach (edge_angles[i])
         angle_queue.push_back({edge_angles[(i + 5) % 14], edge_angles[(i + 3) % 14],
                                edge_angles[i]});
      angle_queue.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff});
      angle_queue.push_back({16'sh8000, 16'sh8000, 16'sh8000});
      angle_queue.push_back({16'sd11520, 16'sd5760, 16'sd17280});
      angle_queue.push_back({-16'sd5760, 16'sd23040, 16'sd0});
      wait_drained();
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 86 : 28) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 86 : 28) : 0;
         for (int n = 0; n < 330; n++) begin
            angle_queue.push_back({rand_angle(), rand_angle(), rand_angle()});
            if (n == 160 && phase == 0) begin
               wait_drained();
               hold_sender = 1;
               repeat (LATENCY) @(posedge clock);
               hold_sender = 0;
            end
         end
         wait_drained();
      end
      repeat (LATENCY + 4) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("FAIL");
      $finish;
   end

endmodule

@@ euler_to_quaternion.f @@
src/e2q_pkg.sv
src/e2q_front.sv
src/e2q_queue.sv
src/e2q_back.sv
src/euler_to_quaternion.sv
bench/tb_euler_to_quaternion.sv
